// File: hdl/pidv_pkg.sv
// Package for the variable-interval PID step block: widths, configuration register
// indexes, sequencer states, accumulator operation codes and divider request/response types.
// No dependencies; the multiplier, divider and top level import it.
package pidv_pkg;

  // Field widths
  localparam int unsigned DATA_W  = 32;           // Q16.16 words and tick counts
  localparam int unsigned MUL_W   = DATA_W + 1;   // shared multiplier operand width
  localparam int unsigned PROD_W  = 2 * MUL_W;    // full signed product width
  localparam int unsigned INTEG_W = 48;           // error integral width
  localparam int unsigned ACC_W   = 82;           // exact Q32.32 sum of all terms
  localparam int unsigned FRAC_W  = 16;           // fractional bits of Q16.16
  localparam int unsigned QUO_W   = DATA_W + 1;   // derivative quotient width
  localparam int unsigned CNT_W   = 6;            // divider step counter width

  // Configuration register indexes
  localparam logic [1:0] REG_SETPOINT   = 2'd0;
  localparam logic [1:0] REG_PROP_GAIN  = 2'd1;
  localparam logic [1:0] REG_INTEG_GAIN = 2'd2;
  localparam logic [1:0] REG_DERIV_GAIN = 2'd3;

  // Sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL_KP,
    ST_MUL_ED,
    ST_INTEG,
    ST_MUL_KIH,
    ST_MUL_KIL,
    ST_ACC_KIL,
    ST_DIV_WAIT,
    ST_MUL_KD,
    ST_ACC_KD,
    ST_OUT
  } state_e;

  // Accumulator operations
  typedef enum logic [1:0] {
    ACC_NONE,
    ACC_LOAD,
    ACC_ADD,
    ACC_ADD16
  } acc_op_e;

  // Divider control and status
  typedef struct packed {
    logic                     start;
    logic signed [QUO_W-1:0]  num;
    logic [DATA_W-1:0]        den;
  } div_req_t;

  typedef struct packed {
    logic                     busy;
    logic signed [QUO_W-1:0]  quo;
  } div_rsp_t;

endpackage

// File: hdl/pid_step_variable_interval.sv
// PID step with variable sample interval, Q16.16. A full item's result time is set by the
// 33-step serial divider for the derivative, with the shared multiplier passes run
// alongside; a proportional-only item skips the integral and derivative passes. One item at a
// time: input ready returns in the cycle after the result is loaded.
// A next item is taken while a result waits and holds in its output step until it drains.
// Reset (rst_ni low, asynchronous) clears gains, setpoint, controller state and output valid.
module pid_step_variable_interval
  import pidv_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  // input items
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [63:0] s_axis_tdata_i,   // [31:0] sample_time, [63:32] position
  // result items
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [31:0] m_axis_tdata_o,   // [31:0] drive
  output logic        m_axis_tuser_o,   // [0] prop_only
  // configuration writes
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i
);

  localparam logic signed [DATA_W-1:0] S32_MAX = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic signed [DATA_W-1:0] S32_MIN = {1'b1, {(DATA_W-1){1'b0}}};
  localparam logic signed [INTEG_W-1:0] S48_MAX = {1'b0, {(INTEG_W-1){1'b1}}};
  localparam logic signed [INTEG_W-1:0] S48_MIN = {1'b1, {(INTEG_W-1){1'b0}}};

  state_e state_q, state_d;

  // configuration
  logic signed [DATA_W-1:0] setpoint_q, kp_q, ki_q, kd_q;

  // controller state
  logic [DATA_W-1:0]         last_time_q;
  logic signed [DATA_W-1:0]  last_error_q;
  logic signed [INTEG_W-1:0] integ_q;

  // per-item work registers
  logic [DATA_W-1:0]         time_q;
  logic signed [DATA_W-1:0]  err_q;
  logic [DATA_W-1:0]         delta_q;
  logic                      prop_q;
  logic signed [INTEG_W-1:0] integ_new_q, integ_new_d;
  logic signed [ACC_W-1:0]   acc_q, acc_d;

  // output register
  logic                      out_valid_q;
  logic signed [DATA_W-1:0]  drive_q, drive_d;
  logic                      out_prop_q;

  // handshake and control
  logic                      in_acc;
  logic                      out_free;
  logic                      out_load;
  logic                      mul_en;
  logic signed [MUL_W-1:0]   mul_a, mul_b;
  logic signed [PROD_W-1:0]  prod;
  acc_op_e                   acc_op;
  logic                      integ_en;
  div_req_t                  div_req;
  div_rsp_t                  div_rsp;

  // input decode
  logic [DATA_W-1:0]         in_time;
  logic signed [DATA_W-1:0]  in_pos;
  logic signed [DATA_W:0]    err_wide;
  logic signed [DATA_W-1:0]  err_sat;
  logic [DATA_W-1:0]         in_delta;

  assign in_time  = s_axis_tdata_i[31:0];
  assign in_pos   = s_axis_tdata_i[63:32];
  assign err_wide = {setpoint_q[DATA_W-1], setpoint_q} - {in_pos[DATA_W-1], in_pos};
  assign in_delta = in_time - last_time_q;

  // error saturated to 32 bits
  always_comb begin
    if (err_wide[DATA_W] != err_wide[DATA_W-1]) begin
      err_sat = err_wide[DATA_W] ? S32_MIN : S32_MAX;
    end else begin
      err_sat = err_wide[DATA_W-1:0];
    end
  end

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign in_acc          = s_axis_tvalid_i && s_axis_tready_o;
  assign out_free        = !out_valid_q || m_axis_tready_i;
  assign cfg_ready_o     = 1'b1;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:     if (in_acc) state_d = ST_MUL_KP;
      ST_MUL_KP:   state_d = ST_MUL_ED;
      ST_MUL_ED:   state_d = prop_q ? ST_OUT : ST_INTEG;
      ST_INTEG:    state_d = ST_MUL_KIH;
      ST_MUL_KIH:  state_d = ST_MUL_KIL;
      ST_MUL_KIL:  state_d = ST_ACC_KIL;
      ST_ACC_KIL:  state_d = ST_DIV_WAIT;
      ST_DIV_WAIT: if (!div_rsp.busy) state_d = ST_MUL_KD;
      ST_MUL_KD:   state_d = ST_ACC_KD;
      ST_ACC_KD:   state_d = ST_OUT;
      ST_OUT:      if (out_free) state_d = ST_IDLE;
      default:     state_d = ST_IDLE;
    endcase
  end

  // sequencer outputs: multiplier operands, accumulator and divider control
  always_comb begin
    mul_en      = 1'b0;
    mul_a       = '0;
    mul_b       = '0;
    acc_op      = ACC_NONE;
    integ_en    = 1'b0;
    out_load    = 1'b0;
    div_req.start = 1'b0;
    div_req.num = {err_q[DATA_W-1], err_q} - {last_error_q[DATA_W-1], last_error_q};
    div_req.den = delta_q;
    case (state_q)
      ST_MUL_KP: begin
        mul_en        = 1'b1;
        mul_a         = MUL_W'(kp_q);
        mul_b         = MUL_W'(err_q);
        div_req.start = !prop_q;
      end
      ST_MUL_ED: begin
        acc_op = ACC_LOAD;
        mul_en = !prop_q;
        mul_a  = MUL_W'(err_q);
        mul_b  = {1'b0, delta_q};
      end
      ST_INTEG: begin
        integ_en = 1'b1;
      end
      ST_MUL_KIH: begin
        mul_en = 1'b1;
        mul_a  = MUL_W'(ki_q);
        mul_b  = MUL_W'($signed(integ_new_q[INTEG_W-1:FRAC_W]));
      end
      ST_MUL_KIL: begin
        acc_op = ACC_ADD16;
        mul_en = 1'b1;
        mul_a  = MUL_W'(ki_q);
        mul_b  = {{(MUL_W-FRAC_W){1'b0}}, integ_new_q[FRAC_W-1:0]};
      end
      ST_ACC_KIL: begin
        acc_op = ACC_ADD;
      end
      ST_MUL_KD: begin
        mul_en = 1'b1;
        mul_a  = MUL_W'(kd_q);
        mul_b  = div_rsp.quo;
      end
      ST_ACC_KD: begin
        acc_op = ACC_ADD;
      end
      ST_OUT: begin
        out_load = out_free;
      end
      default: begin
        mul_en = 1'b0;
      end
    endcase
  end

  pidv_mul u_mul (
    .clk_i  (clk_i),
    .en_i   (mul_en),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .prod_o (prod)
  );

  pidv_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // accumulator of the exact Q32.32 drive sum
  always_comb begin
    case (acc_op)
      ACC_LOAD:  acc_d = ACC_W'(prod);
      ACC_ADD:   acc_d = acc_q + ACC_W'(prod);
      ACC_ADD16: acc_d = acc_q + (ACC_W'(prod) <<< FRAC_W);
      default:   acc_d = acc_q;
    endcase
  end

  // new integral: old integral plus error times interval, saturated to 48 bits
  logic signed [PROD_W-1:0] integ_sum;
  assign integ_sum = PROD_W'(integ_q) + prod;

  always_comb begin
    if (integ_sum > PROD_W'(S48_MAX)) begin
      integ_new_d = S48_MAX;
    end else if (integ_sum < PROD_W'(S48_MIN)) begin
      integ_new_d = S48_MIN;
    end else begin
      integ_new_d = integ_sum[INTEG_W-1:0];
    end
  end

  // drive: floor of the sum over 2^16, saturated to 32 bits
  logic [ACC_W-DATA_W-FRAC_W:0] acc_top;
  assign acc_top = acc_q[ACC_W-1:DATA_W+FRAC_W-1];

  always_comb begin
    if (acc_top != '0 && acc_top != '1) begin
      drive_d = acc_q[ACC_W-1] ? S32_MIN : S32_MAX;
    end else begin
      drive_d = acc_q[DATA_W+FRAC_W-1:FRAC_W];
    end
  end

  // control registers, configuration and controller state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      out_valid_q  <= 1'b0;
      setpoint_q   <= '0;
      kp_q         <= '0;
      ki_q         <= '0;
      kd_q         <= '0;
      last_time_q  <= '0;
      last_error_q <= '0;
      integ_q      <= '0;
    end else begin
      state_q <= state_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          REG_SETPOINT:   setpoint_q <= cfg_data_i;
          REG_PROP_GAIN:  kp_q       <= cfg_data_i;
          REG_INTEG_GAIN: ki_q       <= cfg_data_i;
          REG_DERIV_GAIN: kd_q       <= cfg_data_i;
          default:        setpoint_q <= setpoint_q;
        endcase
      end
      // commit state only for a positive interval
      if (out_load && !prop_q) begin
        last_time_q  <= time_q;
        last_error_q <= err_q;
        integ_q      <= integ_new_q;
      end
    end
  end

  // per-item payload registers
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      time_q  <= in_time;
      err_q   <= err_sat;
      delta_q <= in_delta;
      prop_q  <= (in_delta[DATA_W-1] || in_delta == '0);
    end
    if (integ_en) begin
      integ_new_q <= integ_new_d;
    end
    acc_q <= acc_d;
    if (out_load) begin
      drive_q    <= drive_d;
      out_prop_q <= prop_q;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = drive_q;
  assign m_axis_tuser_o  = out_prop_q;

  // divider result is final before the derivative product is formed
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_MUL_KD) |-> !div_rsp.busy)
    else $error("derivative product taken while divider busy");

  // a proportional-only item leaves the controller state untouched
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_load && prop_q) |=> (last_time_q == $past(last_time_q)
                              && integ_q == $past(integ_q)))
    else $error("proportional-only item changed controller state");

  // a new result appears only from the output state
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid_o) |-> $past(state_q == ST_OUT))
    else $error("result valid raised outside output state");

  // the divider is only started with a positive interval
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_req.start |-> (!delta_q[DATA_W-1] && delta_q != '0))
    else $error("divider started with a non-positive interval");

endmodule

// File: hdl/pidv_mul.sv
// Shared signed multiplier with a registered product.
// Depends on pidv_pkg for operand and product widths.
module pidv_mul
  import pidv_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     en_i,
  input  logic signed [MUL_W-1:0]  a_i,
  input  logic signed [MUL_W-1:0]  b_i,
  output logic signed [PROD_W-1:0] prod_o
);

  logic signed [PROD_W-1:0] prod_d, prod_q;

  // One product per enabled cycle
  assign prod_d = a_i * b_i;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= prod_d;
    end
  end

  assign prod_o = prod_q;

endmodule

// File: hdl/pidv_div.sv
// Radix-2 restoring divider for the derivative term: signed numerator over a
// positive divisor, quotient truncated toward zero. Depends on pidv_pkg.
module pidv_div
  import pidv_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  logic                busy_d, busy_q;
  logic [CNT_W-1:0]    cnt_d, cnt_q;
  logic                neg_d, neg_q;
  logic [DATA_W-1:0]   den_d, den_q;
  logic [DATA_W-1:0]   rem_d, rem_q;
  logic [QUO_W-1:0]    quo_d, quo_q;
  logic [DATA_W:0]     rem_sh;
  logic [DATA_W:0]     trial;
  logic                take;
  logic [QUO_W-1:0]    quo_next;

  // One quotient bit per cycle
  assign rem_sh   = {rem_q, quo_q[QUO_W-1]};
  assign trial    = rem_sh - {1'b0, den_q};
  assign take     = (rem_sh >= {1'b0, den_q});
  assign quo_next = {quo_q[QUO_W-2:0], take};

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    neg_d  = neg_q;
    den_d  = den_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = CNT_W'(QUO_W);
      neg_d  = req_i.num[QUO_W-1];
      den_d  = req_i.den;
      rem_d  = '0;
      quo_d  = req_i.num[QUO_W-1] ? (~req_i.num + 1'b1) : req_i.num;
    end else if (busy_q) begin
      rem_d = take ? trial[DATA_W-1:0] : rem_sh[DATA_W-1:0];
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CNT_W'(1)) begin
        // last bit: apply the sign of the numerator
        busy_d = 1'b0;
        quo_d  = neg_q ? (~quo_next + 1'b1) : quo_next;
      end else begin
        quo_d = quo_next;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    neg_q <= neg_d;
    den_q <= den_d;
    rem_q <= rem_d;
    quo_q <= quo_d;
  end

  assign rsp_o.busy = busy_q;
  assign rsp_o.quo  = quo_q;

endmodule
